// File: hdl/rc4_pkg.sv
// Shared constants, types and the sequencer microcode for the RC4 stream cipher.
// Depends on nothing; used by rc4_stream_cipher.
package rc4_pkg;

  localparam int BYTE_W        = 8;
  localparam int SBOX_DEPTH    = 256;
  localparam int SBOX_AW       = $clog2(SBOX_DEPTH);
  localparam int KEY_W         = 64;
  localparam int KEY_BYTES_DEF = 8;
  localparam int KEY_SEL_W     = $clog2(KEY_W / BYTE_W);
  localparam int STEP_W        = 4;

  // Item kinds carried on tuser
  localparam logic OP_CIPHER = 1'b0;
  localparam logic OP_REKEY  = 1'b1;

  // Microprogram addresses
  typedef enum logic [STEP_W-1:0] {
    S_FILL     = 4'd0,
    S_FILL_END = 4'd1,
    S_KSA0     = 4'd2,
    S_KSA1     = 4'd3,
    S_KSA2     = 4'd4,
    S_KSA3     = 4'd5,
    S_KSA_END  = 4'd6,
    S_IDLE     = 4'd7,
    S_PR0      = 4'd8,
    S_PR1      = 4'd9,
    S_PR2      = 4'd10
  } step_e;

  // Read address select
  typedef enum logic [1:0] {
    RA_INEXT = 2'd0,  // i + 1
    RA_JNEXT = 2'd1,  // freshly summed j
    RA_T     = 2'd2,  // a + read data
    RA_CNT   = 2'd3   // step counter
  } rsel_e;

  // Write address / data select
  typedef enum logic [1:0] {
    WA_CNT_CNT = 2'd0,  // S[cnt] = cnt
    WA_I_RD    = 2'd1,  // S[i]   = read data
    WA_J_A     = 2'd2,  // S[j]   = a
    WA_CNT_RD  = 2'd3   // S[cnt] = read data
  } wsel_e;

  typedef enum logic [1:0] {
    J_HOLD    = 2'd0,
    J_CLEAR   = 2'd1,
    J_ADD_A   = 2'd2,
    J_ADD_KEY = 2'd3
  } jop_e;

  typedef enum logic [1:0] {
    I_HOLD  = 2'd0,
    I_CLEAR = 2'd1,
    I_STEP  = 2'd2
  } iop_e;

  // Sequencing of the step counter
  typedef enum logic [2:0] {
    SEQ_NEXT     = 3'd0,
    SEQ_GOTO     = 3'd1,
    SEQ_LOOP     = 3'd2,  // to target until the counter reaches its top
    SEQ_DISPATCH = 3'd3,  // wait for a transaction, rekey goes to target
    SEQ_KEYED    = 3'd4,  // on to next if rekeying, else to target
    SEQ_OUT      = 3'd5   // hold until the output register is free
  } seq_e;

  typedef struct packed {
    logic  ready;
    logic  rd_en;
    rsel_e rd_sel;
    logic  wr_en;
    wsel_e wr_sel;
    jop_e  j_op;
    iop_e  i_op;
    logic  cnt_inc;
    logic  ld_a;
    logic  ld_b;
    logic  rekey_clr;
    seq_e  seq;
    step_e target;
  } ucode_t;

  // Control store: one word per step
  function automatic ucode_t ucode_rom(input step_e step);
    ucode_t w;
    w = '{ready: 1'b0, rd_en: 1'b0, rd_sel: RA_CNT, wr_en: 1'b0, wr_sel: WA_CNT_CNT,
          j_op: J_HOLD, i_op: I_HOLD, cnt_inc: 1'b0, ld_a: 1'b0, ld_b: 1'b0,
          rekey_clr: 1'b0, seq: SEQ_NEXT, target: S_IDLE};
    case (step)
      S_FILL: begin
        w.wr_en = 1'b1; w.wr_sel = WA_CNT_CNT; w.cnt_inc = 1'b1;
        w.j_op = J_CLEAR; w.i_op = I_CLEAR;
        w.seq = SEQ_LOOP; w.target = S_FILL;
      end
      S_FILL_END: begin
        w.j_op = J_CLEAR; w.seq = SEQ_KEYED; w.target = S_IDLE;
      end
      S_KSA0: begin
        w.rd_en = 1'b1; w.rd_sel = RA_CNT;
      end
      S_KSA1: begin
        w.ld_a = 1'b1; w.j_op = J_ADD_KEY; w.rd_en = 1'b1; w.rd_sel = RA_JNEXT;
      end
      S_KSA2: begin
        w.wr_en = 1'b1; w.wr_sel = WA_CNT_RD;
      end
      S_KSA3: begin
        w.wr_en = 1'b1; w.wr_sel = WA_J_A; w.cnt_inc = 1'b1;
        w.seq = SEQ_LOOP; w.target = S_KSA0;
      end
      S_KSA_END: begin
        w.j_op = J_CLEAR; w.i_op = I_CLEAR; w.rekey_clr = 1'b1;
        w.seq = SEQ_GOTO; w.target = S_IDLE;
      end
      S_IDLE: begin
        w.ready = 1'b1; w.rd_en = 1'b1; w.rd_sel = RA_INEXT; w.i_op = I_STEP;
        w.seq = SEQ_DISPATCH; w.target = S_FILL;
      end
      S_PR0: begin
        w.ld_a = 1'b1; w.j_op = J_ADD_A; w.rd_en = 1'b1; w.rd_sel = RA_JNEXT;
      end
      S_PR1: begin
        w.ld_b = 1'b1; w.wr_en = 1'b1; w.wr_sel = WA_I_RD;
        w.rd_en = 1'b1; w.rd_sel = RA_T;
      end
      S_PR2: begin
        w.wr_en = 1'b1; w.wr_sel = WA_J_A; w.seq = SEQ_OUT; w.target = S_IDLE;
      end
      default: begin
        w.seq = SEQ_GOTO; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: hdl/rc4_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, data held while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rc4_stream_cipher.sv
// RC4 stream cipher: microcoded sequencer over a 256 x 8 permutation RAM.
// Cipher byte: taken in S_IDLE, then S_PR0, S_PR1 and S_PR2, which loads the output
// register or holds while it is full; one byte at a time, as the dependent S[i],
// S[j], S[a+b] reads share the one RAM read port. Rekey: identity fill, then S_KSA0
// to S_KSA3 per key-schedule step. Reset: async active low; clears control and key,
// then a RAM identity fill runs, s_axis_tready low. Depends on rc4_pkg and rc4_ram.
module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Key register write
  input  logic              key_we_i,
  input  logic [KEY_W-1:0]  key_wdata_i,
  // Input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_in
  input  logic              s_axis_tlast,   // last_in
  input  logic              s_axis_tuser,   // [0] op
  // Output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] data_out
  output logic              m_axis_tlast    // last_out
);

  localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  step_e              upc_q, upc_d;
  ucode_t             uc;
  logic               accept, out_free;
  logic               rekey_q, rekey_d;
  logic [SBOX_AW-1:0] i_q, i_d, j_q, j_d, cnt_q;
  logic [KIDX_W-1:0]  kidx_q, kidx_d;
  logic [KEY_W-1:0]   key_q;
  logic [BYTE_W-1:0]  key_byte;
  logic [BYTE_W-1:0]  a_q, b_q, t_q, din_q, ks;
  logic               lin_q;
  logic               out_valid_q;
  logic [BYTE_W-1:0]  out_data_q;
  logic               out_last_q;
  logic               ram_we;
  logic [SBOX_AW-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]  ram_wdata, ram_rdata;
  step_e              step_next;

  // Control word for this step
  assign uc            = ucode_rom(upc_q);
  assign s_axis_tready = uc.ready;
  assign accept        = s_axis_tvalid && uc.ready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step_next     = step_e'(STEP_W'(upc_q) + STEP_W'(1));

  // Sequencer: next step
  always_comb begin
    case (uc.seq)
      SEQ_NEXT:     upc_d = step_next;
      SEQ_GOTO:     upc_d = uc.target;
      SEQ_LOOP:     upc_d = (cnt_q != '1) ? uc.target : step_next;
      SEQ_DISPATCH: upc_d = !accept ? upc_q :
                            (s_axis_tuser == OP_REKEY) ? uc.target : step_next;
      SEQ_KEYED:    upc_d = rekey_q ? step_next : uc.target;
      SEQ_OUT:      upc_d = out_free ? uc.target : upc_q;
      default:      upc_d = S_IDLE;
    endcase
  end

  // Key byte for the current schedule step
  assign key_byte = key_q[{KEY_SEL_W'(kidx_q), 3'b000} +: BYTE_W];

  // Index updates
  always_comb begin
    case (uc.j_op)
      J_CLEAR:   j_d = '0;
      J_ADD_A:   j_d = j_q + ram_rdata;
      J_ADD_KEY: j_d = j_q + ram_rdata + key_byte;
      default:   j_d = j_q;
    endcase
    case (uc.i_op)
      I_CLEAR: i_d = '0;
      I_STEP:  i_d = (accept && s_axis_tuser == OP_CIPHER) ? i_q + 1'b1 : i_q;
      default: i_d = i_q;
    endcase
    if (uc.j_op == J_CLEAR) begin
      kidx_d = '0;
    end else if (uc.cnt_inc) begin
      kidx_d = (kidx_q == KIDX_W'(KEY_BYTES - 1)) ? '0 : kidx_q + 1'b1;
    end else begin
      kidx_d = kidx_q;
    end
    rekey_d = rekey_q;
    if (uc.rekey_clr) begin
      rekey_d = 1'b0;
    end else if (accept && s_axis_tuser == OP_REKEY) begin
      rekey_d = 1'b1;
    end
  end

  // RAM address and data selection
  always_comb begin
    case (uc.rd_sel)
      RA_INEXT: ram_raddr = i_q + 1'b1;
      RA_JNEXT: ram_raddr = j_d;
      RA_T:     ram_raddr = a_q + ram_rdata;
      default:  ram_raddr = cnt_q;
    endcase
    ram_we = uc.wr_en;
    case (uc.wr_sel)
      WA_CNT_CNT: begin ram_waddr = cnt_q; ram_wdata = cnt_q;     end
      WA_I_RD:    begin ram_waddr = i_q;   ram_wdata = ram_rdata; end
      WA_J_A:     begin ram_waddr = j_q;   ram_wdata = a_q;       end
      default:    begin ram_waddr = cnt_q; ram_wdata = ram_rdata; end
    endcase
  end

  // Keystream byte; the S[a+b] read overlaps the swap writes, so bypass them
  always_comb begin
    if (t_q == j_q) begin
      ks = a_q;
    end else if (t_q == i_q) begin
      ks = b_q;
    end else begin
      ks = ram_rdata;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= S_FILL;
      rekey_q     <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      cnt_q       <= '0;
      kidx_q      <= '0;
      key_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q   <= upc_d;
      rekey_q <= rekey_d;
      i_q     <= i_d;
      j_q     <= j_d;
      kidx_q  <= kidx_d;
      if (uc.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (key_we_i) begin
        key_q <= key_wdata_i;
      end
      if (uc.seq == SEQ_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      din_q <= s_axis_tdata;
      lin_q <= s_axis_tlast;
    end
    if (uc.ld_a) begin
      a_q <= ram_rdata;
    end
    if (uc.ld_b) begin
      b_q <= ram_rdata;
      t_q <= a_q + ram_rdata;
    end
    if (uc.seq == SEQ_OUT && out_free) begin
      out_data_q <= din_q ^ ks;
      out_last_q <= lin_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // Permutation store
  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SBOX_DEPTH)
  ) u_sbox (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (uc.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Loops finish with the counter wrapped and no rekey pending
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (cnt_q == '0) && !rekey_q)
    else $error("sequencer idle with loop counter or rekey flag left over");

  // A cipher transaction reaches the output step via S_PR0 and S_PR1
  a_cipher_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_CIPHER) |-> ##3 (upc_q == S_PR2))
    else $error("cipher transaction did not reach the output step");

  // A rekey transaction starts the identity fill
  a_rekey_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_REKEY)
      |=> (upc_q == S_FILL) && rekey_q)
    else $error("rekey transaction did not start the fill");

endmodule

// File: test/rc4_stream_cipher_test.sv
// Self-checking testbench for rc4_stream_cipher: drives cipher and rekey transactions,
// predicts each output byte with its own RC4 state and checks the output stream.
// Depends on rc4_pkg and the rc4_stream_cipher RTL; stands alone otherwise.
`timescale 1ns / 100ps

module rc4_stream_cipher_test;
  import rc4_pkg::*;

  // Rekey runs in the block with no result to wait for
  localparam int REKEY_CYCLES = 1283;
  localparam int QUIET_CYCLES = REKEY_CYCLES + 100;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] data;
    logic              last;
  } cipher_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } cipher_byte_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              key_we_i = 1'b0;
  logic [KEY_W-1:0]  key_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [BYTE_W-1:0] s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              s_axis_tuser = OP_CIPHER;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [BYTE_W-1:0] m_axis_tdata;
  logic              m_axis_tlast;

  rc4_stream_cipher u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_we_i      (key_we_i),
    .key_wdata_i   (key_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stimulus and checking state
  cipher_item_t pending_q[$];
  cipher_byte_t cipher_q[$];
  int           src_idle_pct = 0;
  int           snk_idle_pct = 0;
  bit           sink_hold = 1'b0;
  bit           hold_arm = 1'b0;
  bit           in_took = 1'b0;
  int           errors = 0;
  int           bytes_checked = 0;
  int           rekeys_seen = 0;
  int           key_writes = 0;

  // Own copy of the cipher state
  logic [BYTE_W-1:0] sbox_m [SBOX_DEPTH];
  logic [BYTE_W-1:0] idx_i_m;
  logic [BYTE_W-1:0] idx_j_m;
  logic [KEY_W-1:0]  key_m;

  function automatic void identity_fill();
    for (int n = 0; n < SBOX_DEPTH; n++) sbox_m[n] = n[BYTE_W-1:0];
    idx_i_m = '0;
    idx_j_m = '0;
  endfunction

  // Key schedule: key byte (n mod KEY_BYTES_DEF) at step n
  function automatic void key_schedule();
    logic [BYTE_W-1:0] j;
    logic [BYTE_W-1:0] t;
    j = '0;
    identity_fill();
    for (int n = 0; n < SBOX_DEPTH; n++) begin
      t = sbox_m[n];
      j = j + t + key_m[BYTE_W*(n % KEY_BYTES_DEF) +: BYTE_W];
      sbox_m[n] = sbox_m[j];
      sbox_m[j] = t;
    end
  endfunction

  // One keystream step; indices wrap at 256
  function automatic logic [BYTE_W-1:0] keystream_byte();
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] t;
    idx_i_m = idx_i_m + 8'd1;
    a = sbox_m[idx_i_m];
    idx_j_m = idx_j_m + a;
    b = sbox_m[idx_j_m];
    sbox_m[idx_i_m] = b;
    sbox_m[idx_j_m] = a;
    t = a + b;
    return sbox_m[t];
  endfunction

  // Input side: prediction at each accepted transaction; output side: checking
  always @(posedge clk_i) begin : cipher_check
    cipher_byte_t want;
    if (!rst_ni) begin
      identity_fill();
      key_m   = '0;
      in_took <= 1'b0;
    end else begin
      if (key_we_i) key_m = key_wdata_i;
      in_took <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_REKEY) begin
          key_schedule();
          rekeys_seen++;
        end else begin
          want.data = s_axis_tdata ^ keystream_byte();
          want.last = s_axis_tlast;
          cipher_q.push_back(want);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (cipher_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected output byte %02h last %b", $time, m_axis_tdata,
                   m_axis_tlast);
        end else begin
          want = cipher_q.pop_front();
          bytes_checked++;
          if (want.data !== m_axis_tdata || want.last !== m_axis_tlast) begin
            errors++;
            $display("%0t: mismatch: expected data %02h last %b, got data %02h last %b",
                     $time, want.data, want.last, m_axis_tdata, m_axis_tlast);
          end
        end
      end
    end
  end

  // Driver: keeps tvalid up across back-to-back transactions
  always @(negedge clk_i) begin : item_driver
    cipher_item_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_took) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        it = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= it.data;
        s_axis_tlast  <= it.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin : byte_sink
    m_axis_tready <= !sink_hold && ($urandom_range(99) >= snk_idle_pct);
  end

  // Long receiver stall while the sender keeps offering
  initial begin : output_hold
    wait (hold_arm);
    repeat (1500) @(negedge clk_i);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    sink_hold <= 1'b0;
  end

  function automatic void push_item(input logic op, input logic [BYTE_W-1:0] data,
                                    input logic last);
    cipher_item_t it;
    it.op   = op;
    it.data = data;
    it.last = last;
    pending_q.push_back(it);
  endfunction

  // Everything sent and checked, then room for a rekey still running
  task automatic drain_quiet();
    while (pending_q.size() != 0 || s_axis_tvalid || cipher_q.size() != 0)
      @(negedge clk_i);
    repeat (QUIET_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_key(input logic [KEY_W-1:0] value);
    @(negedge clk_i);
    key_we_i    <= 1'b1;
    key_wdata_i <= value;
    @(negedge clk_i);
    key_we_i    <= 1'b0;
    key_writes++;
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // Mostly buffers (optionally rekeyed first) with last on the final byte; some noise
  function automatic void buffer_traffic(input int count, input int rekey_pct);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 10) begin
        push_item(1'($urandom_range(1)), BYTE_W'($urandom_range(255)),
                  1'($urandom_range(1)));
        sent++;
      end else begin
        if ($urandom_range(99) < rekey_pct) begin
          push_item(OP_REKEY, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
          sent++;
        end
        len = $urandom_range(1, 24);
        for (int n = 0; n < len; n++)
          push_item(OP_CIPHER, BYTE_W'($urandom_range(255)), n == len - 1);
        sent += len;
      end
    end
  endfunction

  initial begin : stimulus
    int len;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: bytes on the identity permutation, then rekey with the reset key
    src_idle_pct = 0;
    snk_idle_pct = 0;
    push_item(OP_CIPHER, 8'h00, 1'b0);
    push_item(OP_CIPHER, 8'hFF, 1'b1);
    push_item(OP_REKEY, 8'hFF, 1'b1);
    push_item(OP_CIPHER, 8'h00, 1'b0);
    push_item(OP_CIPHER, 8'hFF, 1'b0);
    push_item(OP_CIPHER, 8'h5A, 1'b1);
    drain_quiet();

    // Directed: all-ones key, back-to-back rekeys, byte straight after a rekey
    write_key({KEY_W{1'b1}});
    push_item(OP_REKEY, 8'h00, 1'b0);
    push_item(OP_REKEY, 8'hA5, 1'b1);
    push_item(OP_CIPHER, 8'h00, 1'b1);
    push_item(OP_CIPHER, 8'hFF, 1'b0);
    push_item(OP_CIPHER, 8'hA5, 1'b1);
    drain_quiet();
    write_key('0);
    push_item(OP_REKEY, 8'h3C, 1'b0);
    push_item(OP_CIPHER, 8'hFF, 1'b1);
    push_item(OP_CIPHER, 8'h01, 1'b0);
    drain_quiet();

    // Random, sender idles less than receiver
    write_key(random_key());
    src_idle_pct = 34;
    snk_idle_pct = 76;
    push_item(OP_REKEY, 8'h00, 1'b0);
    buffer_traffic(70, 15);
    drain_quiet();

    // Random, the other way round
    write_key(random_key());
    src_idle_pct = 76;
    snk_idle_pct = 34;
    push_item(OP_REKEY, 8'h00, 1'b0);
    buffer_traffic(70, 15);
    drain_quiet();

    // Full rate, one key for more than 256 bytes so both indices wrap; long stall
    write_key(random_key());
    src_idle_pct = 0;
    snk_idle_pct = 0;
    push_item(OP_REKEY, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
    for (int total = 0; total < 270; total += len) begin
      len = $urandom_range(1, 40);
      for (int n = 0; n < len; n++)
        push_item(OP_CIPHER, BYTE_W'($urandom_range(255)), n == len - 1);
    end
    hold_arm = 1'b1;
    drain_quiet();

    $display("Checked %0d cipher bytes over %0d rekeys and %0d key settings.",
             bytes_checked, rekeys_seen, key_writes);
    $display("Idle mixes 34/76, 76/34 and none; one %0d-cycle output stall.", HOLD_CYCLES);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("%0t: timeout", $time);
    $display("TEST FAILED");
    $finish;
  end

endmodule
